/* design/efp_pkg.sv */
// shared constants and types for the peak envelope follower
package efp_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 17;
    localparam int LEVEL_W  = 20;
    localparam int COEF_W   = 16;
    localparam int GAIN_W   = 3;
    localparam int FRAC_W   = 16;

    // apb register map
    localparam int APB_AW = 4;
    localparam logic [APB_AW-1:0] ADDR_ATTACK = 4'h0;
    localparam logic [APB_AW-1:0] ADDR_DECAY  = 4'h4;
    localparam logic [APB_AW-1:0] ADDR_FREEZE = 4'h8;
    localparam logic [APB_AW-1:0] ADDR_GAIN   = 4'hC;

    // register reset values
    localparam logic [COEF_W-1:0] ATTACK_RST = 16'd6554;
    localparam logic [COEF_W-1:0] DECAY_RST  = 16'd6554;
    localparam logic [GAIN_W-1:0] GAIN_RST   = 3'd2;

    // limits and fixed coefficients
    localparam logic [GAIN_W-1:0]  GAIN_SHIFT_MAX = 3'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 20'd524288;
    localparam logic [COEF_W-1:0]  PEAK_FALL_COEF = 16'd6554;

    typedef logic [LEVEL_W-1:0] t_level;

endpackage

/* design/envelope_follower_peak.sv */
// peak envelope follower with attack/decay slewing and slewed block peak
//
// Usage: audio samples enter on the slave stream (s_axis), one word per
// sample, tdata holding the signed sample and tlast marking the final sample
// of a processing block. Each sample gives exactly one output word on the
// master stream (m_axis): the envelope after that sample and the slewed
// block peak. Coefficients, freeze and gain are set through the apb port and
// should be changed only while no word is in flight.
// Pipeline: two register stages, stage a (envelope) and then stage b (output
// register and peak state). Throughput is one sample per cycle while the
// receiver keeps m_axis_tready high: the envelope update is a single 16x21
// multiply and add feeding back into the envelope register, and the peak stage
// has one constant multiply on its own feedback path.
// Reset (synchronous, active low) clears the envelope, block peak and slewed
// peak, empties the pipeline and restores the register defaults.
// When the receiver stalls, the output word holds; one more sample can be
// taken into the first stage, after which s_axis_tready drops until the
// output moves.
module envelope_follower_peak
    import efp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] sample
    input  logic                 s_axis_tlast,   // last_in_block
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,   // [19:0] envelope, [39:20] slewed_peak
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // configuration registers
    logic [COEF_W-1:0] r_attack;
    logic [COEF_W-1:0] r_decay;
    logic              r_freeze;
    logic [GAIN_W-1:0] r_gain;
    logic              cfg_wr;

    // pipeline control
    logic r_a_valid;
    logic r_a_last;
    logic r_o_valid;
    logic o_load;
    logic in_acc;

    // envelope stage
    logic signed [SAMPLE_W-1:0]      sample;
    logic [MAG_W-1:0]                mag;
    logic [GAIN_W-1:0]               shamt;
    logic [LEVEL_W-1:0]              target;
    logic signed [LEVEL_W:0]         err;
    logic [COEF_W-1:0]               coef;
    logic signed [LEVEL_W+COEF_W+1:0] prod;
    logic signed [LEVEL_W+1:0]       step;
    logic signed [LEVEL_W+1:0]       lvl;
    t_level                          r_env;
    t_level                          n_env;

    // peak stage
    t_level                          r_bp;
    t_level                          n_bp;
    t_level                          r_sp;
    t_level                          n_sp;
    t_level                          bp_eff;
    logic signed [LEVEL_W:0]         perr;
    logic signed [LEVEL_W+COEF_W+1:0] pprod;
    logic signed [LEVEL_W+1:0]       pstep;
    logic signed [LEVEL_W+1:0]       pnew;
    t_level                          r_o_env;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack <= ATTACK_RST;
            r_decay  <= DECAY_RST;
            r_freeze <= 1'b0;
            r_gain   <= GAIN_RST;
        end else if (cfg_wr) begin
            case (paddr)
                ADDR_ATTACK: r_attack <= pwdata[COEF_W-1:0];
                ADDR_DECAY:  r_decay  <= pwdata[COEF_W-1:0];
                ADDR_FREEZE: r_freeze <= pwdata[0];
                ADDR_GAIN:   r_gain   <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_ATTACK: prdata = {{(32-COEF_W){1'b0}}, r_attack};
            ADDR_DECAY:  prdata = {{(32-COEF_W){1'b0}}, r_decay};
            ADDR_FREEZE: prdata = {31'd0, r_freeze};
            ADDR_GAIN:   prdata = {{(32-GAIN_W){1'b0}}, r_gain};
            default:     prdata = 32'd0;
        endcase
    end

    // handshake: output register loads when empty or drained
    assign o_load        = !r_o_valid || m_axis_tready;
    assign s_axis_tready = !r_a_valid || o_load;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_sp, r_o_env};

    // rectify and apply gain
    always_comb begin
        sample = s_axis_tdata;
        if (sample[SAMPLE_W-1]) begin
            mag = MAG_W'(17'h10000 - {1'b0, s_axis_tdata});
        end else begin
            mag = {1'b0, s_axis_tdata};
        end
        shamt  = (r_gain > GAIN_SHIFT_MAX) ? GAIN_SHIFT_MAX : r_gain;
        target = LEVEL_W'({{(LEVEL_W-MAG_W){1'b0}}, mag} << shamt);
    end

    // envelope slew toward target
    always_comb begin
        err = $signed({1'b0, target}) - $signed({1'b0, r_env});
        if (r_freeze) begin
            coef = '0;
        end else if (err > 0) begin
            coef = r_attack;
        end else begin
            coef = r_decay;
        end
        prod = $signed({1'b0, coef}) * err;
        step = (LEVEL_W+2)'(prod >>> FRAC_W);
        lvl  = $signed({2'b00, r_env}) + step;
        if (lvl < 0) begin
            n_env = '0;
        end else if (lvl > $signed({2'b00, LEVEL_MAX})) begin
            n_env = LEVEL_MAX;
        end else begin
            n_env = lvl[LEVEL_W-1:0];
        end
    end

    // stage a: envelope state doubles as the stage payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_env     <= '0;
        end else begin
            if (in_acc) begin
                r_a_valid <= 1'b1;
                r_env     <= n_env;
            end else if (o_load) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_last <= s_axis_tlast;
        end
    end

    // block peak fold and slewed peak update
    always_comb begin
        bp_eff = (r_env > r_bp) ? r_env : r_bp;
        perr   = $signed({1'b0, bp_eff}) - $signed({1'b0, r_sp});
        pprod  = $signed({1'b0, PEAK_FALL_COEF}) * perr;
        if (perr > 0) begin
            pstep = (LEVEL_W+2)'(perr >>> 1);
        end else begin
            pstep = (LEVEL_W+2)'(pprod >>> FRAC_W);
        end
        pnew = $signed({2'b00, r_sp}) + pstep;
        n_sp = r_sp;
        n_bp = bp_eff;
        if (r_a_last) begin
            n_bp = '0;
            if (pnew < 0) begin
                n_sp = '0;
            end else if (pnew > $signed({2'b00, LEVEL_MAX})) begin
                n_sp = LEVEL_MAX;
            end else begin
                n_sp = pnew[LEVEL_W-1:0];
            end
        end
    end

    // stage b: output register and peak state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_bp      <= '0;
            r_sp      <= '0;
        end else if (o_load) begin
            r_o_valid <= r_a_valid;
            if (r_a_valid) begin
                r_bp <= n_bp;
                r_sp <= n_sp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && r_a_valid) begin
            r_o_env <= r_env;
        end
    end

`ifndef ASSERT_OFF
    // envelope and peak stay within range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_env <= LEVEL_MAX && r_sp <= LEVEL_MAX))
        else $error("output level out of range");

    // freeze holds the envelope
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_freeze) |=> $stable(r_env))
        else $error("envelope moved while frozen");

    // block peak restarts after a last word moves to the output
    a_bp_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && r_a_valid && r_a_last) |=> (r_bp == '0))
        else $error("block peak not cleared");

    // full pipeline with stalled output takes no word
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_o_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("word accepted into full pipeline");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule
